// ===== rtl/dsa_pkg.sv =====
// Shared types and codes for the descriptor slot allocator.
`default_nettype none

package dsa_pkg;

    // Request modes
    localparam logic [1:0] MODE_ALLOC       = 2'd0;
    localparam logic [1:0] MODE_RELEASE     = 2'd1;
    localparam logic [1:0] MODE_RELEASE_ALL = 2'd2;
    localparam logic [1:0] MODE_LOCATE      = 2'd3;

    // Result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_EMPTY     = 2'd1;
    localparam logic [1:0] ST_RANGE     = 2'd2;
    localparam logic [1:0] ST_SLOT_FREE = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] CFG_SET_COUNT   = 2'd0;
    localparam logic [1:0] CFG_SET_STRIDE  = 2'd1;
    localparam logic [1:0] CFG_BASE_OFFSET = 2'd2;
    localparam logic [1:0] CFG_DESC_STRIDE = 2'd3;

    localparam int CFG_DATA_W = 16;
    localparam int OFFSET_W   = 25;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] slot_index;
        logic [7:0] binding_index;
    } req_t;

    typedef struct packed {
        logic [1:0]          status;
        logic [5:0]          granted_slot;
        logic [OFFSET_W-1:0] byte_offset;
        logic [6:0]          free_count;
    } rsp_t;

    // Locate operands handed to the offset pipeline
    typedef struct packed {
        logic       ok;
        logic [7:0] slot_index;
        logic [7:0] binding_index;
    } off_req_t;

    // Address geometry registers seen by the offset pipeline
    typedef struct packed {
        logic [15:0] set_stride;
        logic [15:0] base_offset;
        logic [8:0]  descriptor_stride;
    } off_cfg_t;

endpackage

`default_nettype wire

// ===== rtl/descriptor_slot_allocator_core.sv =====
// Top level of the descriptor slot allocator: LIFO free list of slot indices.
// Takes one item per cycle (busy never rises); each item gives one result,
// strobed on rsp_valid from the result register after stages A and B, which
// run alongside the locate multiply-add pipeline; the free list updates on acceptance.
// Asynchronous reset, no clearing pass: min(SLOTS, 64) slots free, slot 0 on top.
`default_nettype none

module descriptor_slot_allocator_core #(
    parameter int SLOTS = 64
) (
    input  wire                            clk,
    input  wire                            rst_n,
    input  wire                            start,
    output logic                           busy,
    input  dsa_pkg::req_t                  req,
    output logic                           rsp_valid,
    output dsa_pkg::rsp_t                  rsp,
    input  wire                            cfg_valid,
    output logic                           cfg_ready,
    input  wire [1:0]                      cfg_index,
    input  wire [dsa_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import dsa_pkg::*;

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;  // slot / stack index width
    localparam int DW = $clog2(SLOTS + 1);                // stack depth width
    localparam int N0 = (SLOTS < 64) ? SLOTS : 64;        // slots filled at reset
    localparam logic [8:0]    SLOTS_W = 9'(SLOTS);
    localparam logic [IW-1:0] RESET_TOP_SUM = IW'(N0 - 1);

    // ------------------------------------------------------------------
    // Configuration registers; the port never stalls.
    // ------------------------------------------------------------------
    logic [6:0]  set_count_reg;
    logic [15:0] set_stride_reg;
    logic [15:0] base_offset_reg;
    logic [8:0]  desc_stride_reg;

    assign cfg_ready = 1'b1;
    assign busy      = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_count_reg   <= 7'd64;
            set_stride_reg  <= 16'd64;
            base_offset_reg <= 16'd0;
            desc_stride_reg <= 9'd16;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_SET_COUNT:   set_count_reg   <= cfg_data[6:0];
                CFG_SET_STRIDE:  set_stride_reg  <= cfg_data;
                CFG_BASE_OFFSET: base_offset_reg <= cfg_data;
                CFG_DESC_STRIDE: desc_stride_reg <= cfg_data[8:0];
                default:         ;
            endcase
        end
    end

    // Effective slot count: set_count clamped to the capacity.
    logic [8:0]    eff9;
    logic [DW-1:0] eff_count;

    assign eff9      = ({2'b00, set_count_reg} > SLOTS_W) ? SLOTS_W : {2'b00, set_count_reg};
    assign eff_count = DW'(eff9);

    // ------------------------------------------------------------------
    // Free list state.
    // The stack lives in a RAM. Each stack entry has a written bit; an entry
    // not written since the last fill reads as the fill pattern (descending
    // after reset, ascending after release-all), so a fill needs no pass over the RAM.
    // The current top is held in top_reg, or comes from the RAM read port
    // when the last pop left a written entry on top.
    // ------------------------------------------------------------------
    logic [DW-1:0]    depth_reg;
    logic [SLOTS-1:0] slot_free_reg;
    logic [SLOTS-1:0] written_reg;
    logic             desc_fill_reg;
    logic [IW-1:0]    top_reg;
    logic             top_from_ram_reg;

    logic [IW-1:0] ram_rdata;
    logic [IW-1:0] ram_raddr;
    logic [IW-1:0] top_val;

    logic          accept;
    logic          in_range;
    logic          slot_is_free;
    logic          do_pop;
    logic          do_push;
    logic          do_refill;
    logic          locate_ok;
    logic [1:0]    status_c;
    logic [5:0]    granted_c;
    logic [DW-1:0] depth_next;
    logic [IW-1:0] pop_top_idx;
    logic [IW-1:0] pop_fill_val;
    logic [IW-1:0] push_addr;

    assign accept       = start && !busy;
    assign in_range     = {1'b0, req.slot_index} < eff9;
    assign slot_is_free = slot_free_reg[req.slot_index[IW-1:0]];
    assign top_val      = top_from_ram_reg ? ram_rdata : top_reg;
    assign pop_top_idx  = IW'(depth_reg - DW'(2));
    assign pop_fill_val = desc_fill_reg ? (RESET_TOP_SUM - pop_top_idx) : pop_top_idx;
    assign push_addr    = IW'(depth_reg);
    assign ram_raddr    = IW'(depth_next - DW'(1));

    always_comb
    begin
        status_c   = ST_OK;
        granted_c  = '0;
        depth_next = depth_reg;
        do_pop     = 1'b0;
        do_push    = 1'b0;
        do_refill  = 1'b0;
        locate_ok  = 1'b0;
        if (accept)
        begin
            case (req.mode)
                MODE_ALLOC:
                begin
                    if (depth_reg == '0)
                    begin
                        status_c = ST_EMPTY;
                    end
                    else
                    begin
                        do_pop     = 1'b1;
                        granted_c  = 6'(top_val);
                        depth_next = depth_reg - DW'(1);
                    end
                end
                MODE_RELEASE:
                begin
                    if (!in_range)
                    begin
                        status_c = ST_RANGE;
                    end
                    else if (slot_is_free)
                    begin
                        status_c = ST_SLOT_FREE;
                    end
                    else if (depth_reg != DW'(SLOTS))
                    begin
                        do_push    = 1'b1;
                        depth_next = depth_reg + DW'(1);
                    end
                end
                MODE_RELEASE_ALL:
                begin
                    do_refill  = 1'b1;
                    depth_next = eff_count;
                end
                MODE_LOCATE:
                begin
                    if (!in_range)
                    begin
                        status_c = ST_RANGE;
                    end
                    else if (slot_is_free)
                    begin
                        status_c = ST_SLOT_FREE;
                    end
                    else
                    begin
                        locate_ok = 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    dsa_ram #(
        .WIDTH (IW),
        .DEPTH (SLOTS)
    ) u_stack_ram (
        .clk   (clk),
        .we    (do_push),
        .waddr (push_addr),
        .wdata (req.slot_index[IW-1:0]),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Update depth, membership bits and the top-of-stack tracking.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg        <= DW'(N0);
            written_reg      <= '0;
            desc_fill_reg    <= 1'b1;
            top_reg          <= '0;
            top_from_ram_reg <= 1'b0;
            for (int i = 0; i < SLOTS; i++)
            begin
                slot_free_reg[i] <= (i < N0);
            end
        end
        else
        begin
            depth_reg <= depth_next;
            if (do_pop)
            begin
                slot_free_reg[top_val] <= 1'b0;
                top_reg                <= pop_fill_val;
                top_from_ram_reg       <= written_reg[pop_top_idx];
            end
            else if (do_push)
            begin
                slot_free_reg[req.slot_index[IW-1:0]] <= 1'b1;
                written_reg[push_addr]                <= 1'b1;
                top_reg                               <= req.slot_index[IW-1:0];
                top_from_ram_reg                      <= 1'b0;
            end
            else if (do_refill)
            begin
                written_reg      <= '0;
                desc_fill_reg    <= 1'b0;
                top_reg          <= IW'(eff_count - DW'(1));
                top_from_ram_reg <= 1'b0;
                for (int i = 0; i < SLOTS; i++)
                begin
                    slot_free_reg[i] <= (9'(i) < eff9);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result pipeline: stage A holds the decision, the offset unit adds two
    // more stages, and the sideband fields ride along to the result register.
    // ------------------------------------------------------------------
    logic       a_valid_reg;
    logic       b_valid_reg;
    logic       r_valid_reg;
    logic [1:0] a_status_reg;
    logic [1:0] b_status_reg;
    logic [1:0] r_status_reg;
    logic [5:0] a_granted_reg;
    logic [5:0] b_granted_reg;
    logic [5:0] r_granted_reg;
    logic [6:0] a_free_reg;
    logic [6:0] b_free_reg;
    logic [6:0] r_free_reg;
    off_req_t   a_off_reg;
    off_cfg_t   off_cfg;
    logic [OFFSET_W-1:0] offset_out;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            r_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= accept;
            b_valid_reg <= a_valid_reg;
            r_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        a_status_reg            <= status_c;
        a_granted_reg           <= granted_c;
        a_free_reg              <= 7'(depth_next);
        a_off_reg.ok            <= locate_ok;
        a_off_reg.slot_index    <= req.slot_index;
        a_off_reg.binding_index <= req.binding_index;
        b_status_reg            <= a_status_reg;
        b_granted_reg           <= a_granted_reg;
        b_free_reg              <= a_free_reg;
        r_status_reg            <= b_status_reg;
        r_granted_reg           <= b_granted_reg;
        r_free_reg              <= b_free_reg;
    end

    assign off_cfg.set_stride        = set_stride_reg;
    assign off_cfg.base_offset       = base_offset_reg;
    assign off_cfg.descriptor_stride = desc_stride_reg;

    dsa_offset u_offset (
        .clk         (clk),
        .off_req     (a_off_reg),
        .off_cfg     (off_cfg),
        .byte_offset (offset_out)
    );

    assign rsp_valid        = r_valid_reg;
    assign rsp.status       = r_status_reg;
    assign rsp.granted_slot = r_granted_reg;
    assign rsp.byte_offset  = offset_out;
    assign rsp.free_count   = r_free_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##3 rsp_valid)
        else $error("accepted item gave no result after three cycles");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> $past(accept, 3))
        else $error("result strobe without an accepted item");

    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= DW'(SLOTS))
        else $error("free list depth above capacity");

    a_pop_depth: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && req.mode == MODE_ALLOC && depth_reg != '0)
            |=> depth_reg == $past(depth_reg) - DW'(1))
        else $error("allocate did not pop exactly one entry");

endmodule

`default_nettype wire

// ===== rtl/dsa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module dsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire                                       clk,
    input  wire                                       we,
    input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire [WIDTH-1:0]                           wdata,
    input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/dsa_offset.sv =====
// Two-stage multiply-add pipeline for the locate byte offset.
`default_nettype none

module dsa_offset (
    input  wire                                clk,
    input  dsa_pkg::off_req_t                  off_req,
    input  dsa_pkg::off_cfg_t                  off_cfg,
    output logic [dsa_pkg::OFFSET_W-1:0]       byte_offset
);
    import dsa_pkg::*;

    logic [23:0] slot_prod_reg;
    logic [16:0] bind_prod_reg;
    logic        ok_reg;

    // Stage 1: both products
    always_ff @(posedge clk)
    begin
        slot_prod_reg <= 24'(off_req.slot_index * off_cfg.set_stride);
        bind_prod_reg <= 17'(off_req.binding_index * off_cfg.descriptor_stride);
        ok_reg        <= off_req.ok;
    end

    // Stage 2: sum, zero unless the request was an accepted locate
    always_ff @(posedge clk)
    begin
        if (ok_reg)
        begin
            byte_offset <= OFFSET_W'(off_cfg.base_offset) + OFFSET_W'(slot_prod_reg)
                         + OFFSET_W'(bind_prod_reg);
        end
        else
        begin
            byte_offset <= '0;
        end
    end

endmodule

`default_nettype wire
